// ----- rtl/pft3_pkg.sv -----
`default_nettype none

package pft3_pkg;

  localparam int SAMPLE_W      = 24;
  localparam int HEIGHT_W      = 24;
  localparam int BIN_W         = 11;
  localparam int THR_W         = 23;
  localparam int NUM_RANKS     = 3;
  localparam int BIN_COUNT_DEF = 1024;
  localparam int OUT_TDATA_W   = 112;

  localparam logic [THR_W-1:0] THR_RESET = 23'd77;

  // Last rank of a run; its result closes the run.
  localparam logic [1:0] RANK_LAST = 2'd2;

  // One ranked peak; key is the smaller side height.
  typedef struct packed {
    logic [BIN_W-1:0]    bin;
    logic [BIN_W-1:0]    lturn;
    logic [BIN_W-1:0]    rturn;
    logic [HEIGHT_W-1:0] lh;
    logic [HEIGHT_W-1:0] rh;
    logic [HEIGHT_W-1:0] key;
  } peak_t;

  typedef struct packed {
    logic clear;
    logic insert;
  } rank_ctl_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_FETCH,
    S_CHECK,
    S_LSTART,
    S_LWALK,
    S_RSTART,
    S_RWALK,
    S_EVAL,
    S_KEY,
    S_INSERT,
    S_NEXT,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/pft3_ram.sv -----
`default_nettype none

module pft3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/pft3_rank.sv -----
`default_nettype none

module pft3_rank (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pft3_pkg::rank_ctl_t  ctl,
  input  wire pft3_pkg::peak_t      cand,
  input  wire logic [1:0]           rd_idx,
  output pft3_pkg::peak_t           rd_entry,
  output logic [1:0]                held
);

  pft3_pkg::peak_t ent [0:pft3_pkg::NUM_RANKS-1];
  logic [1:0] pos;
  logic       go;
  logic       do_ins;

  // Walk up from the tail while the candidate beats the entry above it.
  always_comb begin
    pos = held;
    go  = 1'b1;
    for (int k = pft3_pkg::NUM_RANKS - 1; k >= 0; k--) begin
      if (go && (2'(k) < held)) begin
        if (cand.key > ent[k].key) begin
          pos = 2'(k);
        end else begin
          go = 1'b0;
        end
      end
    end
  end

  assign do_ins = ctl.insert && (pos != 2'(pft3_pkg::NUM_RANKS));

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (ctl.clear) begin
      held <= '0;
    end else if (do_ins && (held != 2'(pft3_pkg::NUM_RANKS))) begin
      held <= held + 2'd1;
    end
  end

  // Shift weaker entries down one place, then drop the candidate in.
  always_ff @(posedge clk) begin
    if (!ctl.clear && do_ins) begin
      for (int k = 1; k < pft3_pkg::NUM_RANKS; k++) begin
        if ((2'(k) > pos) && (2'(k) <= held)) begin
          ent[k] <= ent[k-1];
        end
      end
      ent[pos] <= cand;
    end
  end

  assign rd_entry = ent[rd_idx];

endmodule

`default_nettype wire

// ----- rtl/peak_finder_top_three.sv -----
// Prominence peak finder. Stream one waveform of signed Q16.8 samples in on
// s_* (one item per cycle, bins numbered from 1); the item with s_tlast
// closes the waveform. Samples past BIN_COUNT are dropped, but their last
// mark still closes the run. After the last item the block stops taking
// items and searches the stored waveform: every inner bin strictly above
// both neighbors is a peak, its left and right descents are followed to
// the turning bins, and the peak is kept when both side heights exceed
// height_threshold (written through cfg_we/cfg_wdata, reset 77 = 0.3).
// Kept peaks are ranked by the smaller side height, strongest first, ties
// to the lower bin. Three result items follow on m_*, rank 0..2, with
// m_tlast on rank 2; an empty rank carries m_tuser low and zeros apart
// from its rank field. The search runs on the single read port of the
// sample memory and visits each bin, each descent step and each peak in
// turn, then sends the results, waiting out any output stall. The sample
// memory needs no clearing pass: only bins written in the current run are
// read.

`default_nettype none

module peak_finder_top_three #(
  parameter int BIN_COUNT = pft3_pkg::BIN_COUNT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration: height_threshold
  input  wire logic                               cfg_we,
  input  wire logic [pft3_pkg::THR_W-1:0]         cfg_wdata,
  // input items
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [pft3_pkg::SAMPLE_W-1:0]      s_tdata,   // [23:0] sample
  input  wire logic                               s_tlast,   // last
  // result items
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [1:0] rank, [12:2] peak_bin, [36:13] key, [47:37] left_turn,
  // [71:48] left_height, [82:72] right_turn, [106:83] right_height,
  // [111:107] zero
  output logic [pft3_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                    m_tuser,   // found
  output logic                                    m_tlast    // final_res
);

  localparam int AW = $clog2(BIN_COUNT);
  localparam int CW = $clog2(BIN_COUNT + 1);
  localparam int SW = pft3_pkg::SAMPLE_W;
  localparam int HW = pft3_pkg::HEIGHT_W;
  localparam int BW = pft3_pkg::BIN_W;
  localparam int PAD_W = pft3_pkg::OUT_TDATA_W - 2 - 3 * BW - 4 * HW + HW;
  localparam logic [CW-1:0] FULL = CW'(BIN_COUNT);

  pft3_pkg::state_t state, state_next;

  logic [pft3_pkg::THR_W-1:0] thr;
  logic [CW-1:0]  count;       // samples stored in this run
  logic [CW-1:0]  n_bins;      // length of the waveform being searched
  logic [CW-1:0]  n_fin;
  logic [AW-1:0]  addr, addr_next;
  logic [1:0]     fill;        // window fill while priming
  logic [CW-1:0]  hi;          // bin of the newest window sample
  logic signed [SW-1:0] va, vb, vc;   // window: bins hi-2, hi-1, hi
  logic signed [SW-1:0] lv, rv;       // values at the descent fronts
  logic [CW-1:0]  lbin, rbin;
  logic [HW-1:0]  lh, rh, key;
  logic           pass;
  logic [1:0]     emit_k;

  logic           acc, acc_last, store_ok, peak, out_free, load_out;
  logic           l_down, r_down;
  logic [SW-1:0]  ram_rdata;
  logic signed [SW-1:0] rd_val;

  pft3_pkg::rank_ctl_t rank_ctl;
  pft3_pkg::peak_t     cand, entry;
  logic [1:0]          held;
  logic                found;

  assign acc      = s_tvalid && s_tready;
  assign acc_last = acc && s_tlast;
  assign store_ok = count < FULL;
  assign n_fin    = store_ok ? count + CW'(1) : count;
  assign rd_val   = ram_rdata;
  assign peak     = (vb > va) && (vb > vc);
  assign l_down   = rd_val < lv;
  assign r_down   = rd_val < rv;
  assign out_free = !m_tvalid || m_tready;

  pft3_ram #(
    .WIDTH (SW),
    .DEPTH (BIN_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (acc && store_ok),
    .waddr (count[AW-1:0]),
    .wdata (s_tdata),
    .raddr (addr_next),
    .rdata (ram_rdata)
  );

  // Next state and read address. Hold the address by default so the read
  // data keeps showing the bin at addr.
  always_comb begin
    state_next = state;
    addr_next  = addr;
    unique case (state)
      pft3_pkg::S_LOAD: begin
        if (acc_last) begin
          if (n_fin < CW'(3)) begin
            state_next = pft3_pkg::S_EMIT;
          end else begin
            addr_next  = '0;
            state_next = pft3_pkg::S_FETCH;
          end
        end
      end
      pft3_pkg::S_FETCH: begin
        if (fill == 2'd2) begin
          state_next = pft3_pkg::S_CHECK;
        end else begin
          addr_next = addr + AW'(1);
        end
      end
      pft3_pkg::S_CHECK: begin
        state_next = peak ? pft3_pkg::S_LSTART : pft3_pkg::S_NEXT;
      end
      pft3_pkg::S_LSTART: begin
        if (lbin > CW'(1)) begin
          addr_next  = AW'(lbin - CW'(2));
          state_next = pft3_pkg::S_LWALK;
        end else begin
          state_next = pft3_pkg::S_RSTART;
        end
      end
      pft3_pkg::S_LWALK: begin
        state_next = l_down ? pft3_pkg::S_LSTART : pft3_pkg::S_RSTART;
      end
      pft3_pkg::S_RSTART: begin
        if (rbin < n_bins) begin
          addr_next  = AW'(rbin);
          state_next = pft3_pkg::S_RWALK;
        end else begin
          state_next = pft3_pkg::S_EVAL;
        end
      end
      pft3_pkg::S_RWALK: begin
        state_next = r_down ? pft3_pkg::S_RSTART : pft3_pkg::S_EVAL;
      end
      pft3_pkg::S_EVAL:   state_next = pft3_pkg::S_KEY;
      pft3_pkg::S_KEY:    state_next = pft3_pkg::S_INSERT;
      pft3_pkg::S_INSERT: state_next = pft3_pkg::S_NEXT;
      pft3_pkg::S_NEXT: begin
        if (hi < n_bins) begin
          addr_next  = AW'(hi);
          state_next = pft3_pkg::S_FETCH;
        end else begin
          state_next = pft3_pkg::S_EMIT;
        end
      end
      pft3_pkg::S_EMIT: begin
        if (out_free && (emit_k == pft3_pkg::RANK_LAST)) begin
          state_next = pft3_pkg::S_LOAD;
        end
      end
      default: state_next = pft3_pkg::S_LOAD;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_tready        = 1'b0;
    rank_ctl.clear  = 1'b0;
    rank_ctl.insert = 1'b0;
    load_out        = 1'b0;
    unique case (state)
      pft3_pkg::S_LOAD: begin
        s_tready       = 1'b1;
        rank_ctl.clear = acc_last;
      end
      pft3_pkg::S_INSERT: rank_ctl.insert = pass;
      pft3_pkg::S_EMIT:   load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pft3_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= pft3_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // Sample count: saturate at the store depth, restart on the last item.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (acc_last) begin
      count <= '0;
    end else if (acc && store_ok) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      emit_k <= '0;
    end else begin
      if (acc_last) begin
        fill <= '0;
      end else if ((state == pft3_pkg::S_FETCH) && (fill != 2'd2)) begin
        fill <= fill + 2'd1;
      end
      if (load_out) begin
        emit_k <= (emit_k == pft3_pkg::RANK_LAST) ? 2'd0 : emit_k + 2'd1;
      end
    end
  end

  // Search datapath.
  always_ff @(posedge clk) begin
    addr <= addr_next;
    if (acc_last) begin
      n_bins <= n_fin;
    end
    unique case (state)
      pft3_pkg::S_FETCH: begin
        va <= vb;
        vb <= vc;
        vc <= rd_val;
        hi <= CW'(addr) + CW'(1);
      end
      pft3_pkg::S_CHECK: begin
        lbin <= hi - CW'(2);
        lv   <= va;
        rbin <= hi;
        rv   <= vc;
      end
      pft3_pkg::S_LWALK: begin
        if (l_down) begin
          lbin <= lbin - CW'(1);
          lv   <= rd_val;
        end
      end
      pft3_pkg::S_RWALK: begin
        if (r_down) begin
          rbin <= rbin + CW'(1);
          rv   <= rd_val;
        end
      end
      pft3_pkg::S_EVAL: begin
        lh <= HW'(vb - lv);
        rh <= HW'(vb - rv);
      end
      pft3_pkg::S_KEY: begin
        key  <= (lh < rh) ? lh : rh;
        pass <= (lh > HW'(thr)) && (rh > HW'(thr));
      end
      default: ;
    endcase
  end

  assign cand.bin   = BW'(hi - CW'(1));
  assign cand.lturn = BW'(lbin);
  assign cand.rturn = BW'(rbin);
  assign cand.lh    = lh;
  assign cand.rh    = rh;
  assign cand.key   = key;

  pft3_rank u_rank (
    .clk      (clk),
    .rst      (rst),
    .ctl      (rank_ctl),
    .cand     (cand),
    .rd_idx   (emit_k),
    .rd_entry (entry),
    .held     (held)
  );

  assign found = emit_k < held;

  // Output register: an empty rank goes out as zeros apart from its rank field.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= found;
      m_tlast <= emit_k == pft3_pkg::RANK_LAST;
      if (found) begin
        m_tdata <= {PAD_W'(0), entry.rh, entry.rturn, entry.lh, entry.lturn,
                    entry.key, entry.bin, emit_k};
      end else begin
        m_tdata <= {(pft3_pkg::OUT_TDATA_W - 2)'(0), emit_k};
      end
    end
  end

  a_check_window: assert property (@(posedge clk) disable iff (rst)
    (state == pft3_pkg::S_CHECK) |-> (hi >= CW'(3)) && (hi <= n_bins))
    else $error("peak window outside the stored waveform");

  a_left_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == pft3_pkg::S_LWALK) |-> (lbin > CW'(1)))
    else $error("left descent read below bin 1");

  a_right_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == pft3_pkg::S_RWALK) |-> (rbin < n_bins))
    else $error("right descent read past the waveform");

  a_last_rank: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[1:0] == pft3_pkg::RANK_LAST)))
    else $error("run closed on the wrong rank");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != pft3_pkg::S_LOAD) |=> (count == '0))
    else $error("sample stored during search");

endmodule

`default_nettype wire
